### rtl/llpph_pkg.sv
package llpph_pkg;

  localparam int PIX_W   = 8;
  localparam int LWID_W  = 13;
  localparam int COL_W   = 12;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GREEN_MARGIN = 2'd1;
  localparam logic [1:0] REG_WHITE_LEVEL  = 2'd2;

  localparam logic [LWID_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [PIX_W-1:0]  GREEN_MARGIN_RST = 8'd20;
  localparam logic [PIX_W-1:0]  WHITE_LEVEL_RST  = 8'd200;

  typedef struct packed {
    logic [LWID_W-1:0] line_width;
    logic [PIX_W-1:0]  green_margin;
    logic [PIX_W-1:0]  white_level;
  } cfg_t;

endpackage

### rtl/llpph_if.sv
interface llpph_pix_if import llpph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface llpph_res_if import llpph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             left_found;
  logic [COL_W-1:0] left_column;
  logic             right_found;
  logic [COL_W-1:0] right_column;

  modport source (output valid, left_found, left_column, right_found, right_column,
                  input ready);
  modport sink   (input valid, left_found, left_column, right_found, right_column,
                  output ready);
endinterface

### rtl/llpph_cfg.sv
module llpph_cfg import llpph_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width   <= LINE_WIDTH_RST;
      cfg_r.green_margin <= GREEN_MARGIN_RST;
      cfg_r.white_level  <= WHITE_LEVEL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LINE_WIDTH:   cfg_r.line_width   <= pwdata[LWID_W-1:0];
        REG_GREEN_MARGIN: cfg_r.green_margin <= pwdata[PIX_W-1:0];
        REG_WHITE_LEVEL:  cfg_r.white_level  <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_WIDTH:   prdata = CFG_DW'(cfg_r.line_width);
      REG_GREEN_MARGIN: prdata = CFG_DW'(cfg_r.green_margin);
      REG_WHITE_LEVEL:  prdata = CFG_DW'(cfg_r.white_level);
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/laser_line_peak_per_half_top.sv
// A line's result is registered on its last pixel's transfer, presented the cycle after.
// One pixel per cycle unless a closing pixel waits; the per-pixel compare and running
// maximum are combinational between the pixel port and the line state registers.
// A last-column pixel waits only while a previous result is still held at the output.
// Reset (synchronous, rst_n low): line state cleared, no result pending, registers at
// line_width 640, green_margin 20, white_level 200.
module laser_line_peak_per_half_top import llpph_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  llpph_pix_if.sink         in_pix,
  llpph_res_if.source       out_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Column counter width, width of the effective-width arithmetic, and a width
  // wide enough to slice the 12-bit output column from a stored column.
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW + 1 > LWID_W) ? CW + 1 : LWID_W;
  localparam int XW = (CW > COL_W) ? CW : COL_W;

  cfg_t cfg;

  llpph_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Line state.
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic             l_seen_r, l_seen_nxt;
  logic [CW-1:0]    l_col_r, l_col_nxt;
  logic [PIX_W-1:0] l_grn_r, l_grn_nxt;
  logic             r_seen_r, r_seen_nxt;
  logic [CW-1:0]    r_col_r, r_col_nxt;
  logic [PIX_W-1:0] r_grn_r, r_grn_nxt;

  // Result register.
  logic             out_vld_r, out_vld_nxt;
  logic             o_lf_r, o_rf_r;
  logic [COL_W-1:0] o_lc_r, o_rc_r;

  logic [EW-1:0] lw_ext, eff_w, last_col, half_w, col_ext, col_sat;
  logic [CW-1:0] col;
  logic          is_last, in_xfer, out_xfer, qual, in_left;
  logic [XW-1:0] l_col_x, r_col_x;

  // The effective width is the programmed width clamped into [2, MAX_WIDTH].
  // A column count already past the last column (width lowered mid-line) is
  // treated as the last column.
  always_comb begin
    lw_ext = EW'(cfg.line_width);
    if (lw_ext < EW'(2)) begin
      eff_w = EW'(2);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    last_col = eff_w - EW'(1);
    half_w   = eff_w >> 1;
    col_ext  = EW'(col_cnt_r);
    col_sat  = (col_ext > last_col) ? last_col : col_ext;
    col      = col_sat[CW-1:0];
    is_last  = (col_sat >= last_col);
    in_left  = (col_sat < half_w);
  end

  // Pixels that do not close a line are always taken; the closing pixel needs
  // room in the result register.
  assign out_xfer     = out_vld_r && out_res.ready;
  assign in_pix.ready = !is_last || !out_vld_r || out_res.ready;
  assign in_xfer      = in_pix.valid && in_pix.ready;

  // Green must beat red and blue by more than the margin, or all three
  // channels are above the white level. The sums are carried one bit wider.
  assign qual = (({1'b0, in_pix.green} > ({1'b0, in_pix.red}  + {1'b0, cfg.green_margin})) &&
                 ({1'b0, in_pix.green} > ({1'b0, in_pix.blue} + {1'b0, cfg.green_margin})))
             || ((in_pix.red   > cfg.white_level) &&
                 (in_pix.green > cfg.white_level) &&
                 (in_pix.blue  > cfg.white_level));

  // Running maximum per half: a strictly greater green replaces the kept pixel,
  // so the earliest pixel wins a tie.
  always_comb begin
    l_seen_nxt = l_seen_r;
    l_col_nxt  = l_col_r;
    l_grn_nxt  = l_grn_r;
    r_seen_nxt = r_seen_r;
    r_col_nxt  = r_col_r;
    r_grn_nxt  = r_grn_r;
    if (qual) begin
      if (in_left) begin
        if (!l_seen_r || (in_pix.green > l_grn_r)) begin
          l_seen_nxt = 1'b1;
          l_col_nxt  = col;
          l_grn_nxt  = in_pix.green;
        end
      end else begin
        if (!r_seen_r || (in_pix.green > r_grn_r)) begin
          r_seen_nxt = 1'b1;
          r_col_nxt  = col;
          r_grn_nxt  = in_pix.green;
        end
      end
    end
    col_cnt_nxt = col + CW'(1);
    l_col_x     = XW'(l_col_nxt);
    r_col_x     = XW'(r_col_nxt);
    out_vld_nxt = out_vld_r && !out_xfer;
    if (in_xfer && is_last) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      l_seen_r  <= 1'b0;
      l_col_r   <= '0;
      l_grn_r   <= '0;
      r_seen_r  <= 1'b0;
      r_col_r   <= '0;
      r_grn_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_xfer) begin
        if (is_last) begin
          col_cnt_r <= '0;
          l_seen_r  <= 1'b0;
          l_col_r   <= '0;
          l_grn_r   <= '0;
          r_seen_r  <= 1'b0;
          r_col_r   <= '0;
          r_grn_r   <= '0;
        end else begin
          col_cnt_r <= col_cnt_nxt;
          l_seen_r  <= l_seen_nxt;
          l_col_r   <= l_col_nxt;
          l_grn_r   <= l_grn_nxt;
          r_seen_r  <= r_seen_nxt;
          r_col_r   <= r_col_nxt;
          r_grn_r   <= r_grn_nxt;
        end
      end
    end
  end

  // Result payload is loaded only by the closing pixel's transfer. A half with
  // no qualifying pixel reports column zero, which the cleared state holds.
  always_ff @(posedge clk) begin
    if (in_xfer && is_last) begin
      o_lf_r <= l_seen_nxt;
      o_lc_r <= l_col_x[COL_W-1:0];
      o_rf_r <= r_seen_nxt;
      o_rc_r <= r_col_x[COL_W-1:0];
    end
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.left_found   = o_lf_r;
  assign out_res.left_column  = o_lc_r;
  assign out_res.right_found  = o_rf_r;
  assign out_res.right_column = o_rc_r;

  // The closing pixel always leaves a result pending.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_last) |=> out_vld_r)
    else $error("closing pixel did not produce a result");

  // A non-closing pixel advances the column counter by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !is_last) |=> (col_cnt_r == $past(col) + CW'(1)))
    else $error("column counter did not advance");

  // A half that saw nothing reports column zero.
  a_empty_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((o_lf_r || (o_lc_r == '0)) && (o_rf_r || (o_rc_r == '0))))
    else $error("empty half reports a nonzero column");

  // A pending result that is not taken is never overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res.ready) |-> !(in_xfer && is_last))
    else $error("result overwritten while stalled");

endmodule
